FILE: hdl/rdac_pkg.sv
// Shared types, constants and helper functions of the range deadband axis controller.
// No dependencies; every other file of the block imports this package.
package rdac_pkg;

  localparam int unsigned AXIS_COUNT_DEF = 6;
  localparam int unsigned NUM_GAIN       = 6;
  localparam int unsigned AXIS_W         = 3;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned GAIN_W         = 24;
  localparam int unsigned WEIGHT_W       = 17;
  localparam int unsigned ERR_W          = 35;
  localparam int unsigned PROD_W         = GAIN_W + 1 + ERR_W;
  localparam int unsigned SHIFT_W        = PROD_W - 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Q1.16 one, the 0.05 band and twice the band.
  localparam logic [WEIGHT_W-1:0] ONE_Q   = 17'd65536;
  localparam logic [GAIN_W-1:0]   GAIN_RST = 24'd65536;
  localparam int                  BAND_Q  = 3277;
  localparam int                  BAND2_Q = 2 * BAND_Q;

  localparam logic [1:0] MODE_PROP  = 2'd0;
  localparam logic [1:0] MODE_RANGE = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LAST  = 3'd6;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic [GAIN_W-1:0]       gain;
    logic signed [VAL_W-1:0] target;
    logic [WEIGHT_W-1:0]     weight;
  } q_entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              not_empty;
    logic              space;
  } q_stat_t;

  // Clamps a wide signed value to the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SHIFT_W-1:0] v);
    logic signed [SHIFT_W-1:0] hi_lim;
    logic signed [SHIFT_W-1:0] lo_lim;
    hi_lim = SHIFT_W'(64'sd2147483647);
    lo_lim = SHIFT_W'(-64'sd2147483648);
    if (v > hi_lim) begin
      sat_val = 32'sh7FFFFFFF;
    end else if (v < lo_lim) begin
      sat_val = 32'sh80000000;
    end else begin
      sat_val = v[VAL_W-1:0];
    end
  endfunction

endpackage

FILE: hdl/rdac_in_if.sv
// Input channel of the axis controller: one axis sample per word.
// Depends on rdac_pkg for field widths.
interface rdac_in_if;
  import rdac_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [AXIS_W-1:0]       axis_index;
  logic signed [VAL_W-1:0] measured;
  logic signed [VAL_W-1:0] range_lo;
  logic signed [VAL_W-1:0] range_hi;
  logic                    axis_enabled;
  logic signed [VAL_W-1:0] desired_in;

  modport source(output valid, axis_index, measured, range_lo, range_hi, axis_enabled,
                 desired_in, input ready);
  modport sink(input valid, axis_index, measured, range_lo, range_hi, axis_enabled,
               desired_in, output ready);
endinterface

FILE: hdl/rdac_out_if.sv
// Result channel of the axis controller: rate, target and weight per word.
// Depends on rdac_pkg for field widths.
interface rdac_out_if;
  import rdac_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] rate_out;
  logic signed [VAL_W-1:0] desired_out;
  logic [WEIGHT_W-1:0]     weight_out;

  modport source(output valid, rate_out, desired_out, weight_out, input ready);
  modport sink(input valid, rate_out, desired_out, weight_out, output ready);
endinterface

FILE: hdl/rdac_front.sv
// Front end: configuration registers, sample capture, classification, target and
// weight computation, held weight store. Depends on rdac_pkg and rdac_in_if.
module rdac_front #(
  parameter int unsigned AXIS_COUNT = rdac_pkg::AXIS_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_en,
  input  logic [rdac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rdac_pkg::CFG_DATA_W-1:0]  cfg_data,
  rdac_in_if.sink                          in_ch,
  input  logic                             q_space,
  output logic                             push,
  output rdac_pkg::q_entry_t               push_data
);
  import rdac_pkg::*;

  localparam int unsigned AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  logic [1:0]        mode_r;
  logic [GAIN_W-1:0] gain_r [NUM_GAIN];
  logic [WEIGHT_W-1:0] held_r [AXIS_COUNT];

  // Capture stage.
  logic                    a_v_r;
  logic [AXIS_W-1:0]       axis_r;
  logic                    bad_r;
  logic                    en_r;
  logic signed [VAL_W-1:0] value_r, lo_r, hi_r, want_r;
  logic signed [VAL_W:0]   dh_r, dl_r, dw_r, ss_r;

  logic signed [VAL_W:0]   dh_nxt, dl_nxt, dw_nxt, width_nxt, ss_nxt;
  logic                    a_adv;

  assign dh_nxt    = {in_ch.measured[VAL_W-1], in_ch.measured}
                     - {in_ch.range_hi[VAL_W-1], in_ch.range_hi};
  assign dl_nxt    = {in_ch.range_lo[VAL_W-1], in_ch.range_lo}
                     - {in_ch.measured[VAL_W-1], in_ch.measured};
  assign dw_nxt    = {in_ch.desired_in[VAL_W-1], in_ch.desired_in}
                     - {in_ch.measured[VAL_W-1], in_ch.measured};
  assign width_nxt = {in_ch.range_hi[VAL_W-1], in_ch.range_hi}
                     - {in_ch.range_lo[VAL_W-1], in_ch.range_lo};
  // A range narrower than twice the band uses half its width, rounded down.
  assign ss_nxt    = (width_nxt < (VAL_W+1)'(BAND2_Q)) ? (width_nxt >>> 1)
                                                       : (VAL_W+1)'(BAND_Q);

  assign a_adv       = !a_v_r || q_space;
  assign in_ch.ready = a_adv;
  assign push        = a_v_r && q_space;

  // Classification and result selection.
  logic [AW-1:0]             idx;
  logic signed [VAL_W+1:0]   et, eb, top, bot;
  logic                      above, below, outside;
  logic signed [VAL_W+6:0]   dh_w, dl_w, wl, wh;
  logic [WEIGHT_W-1:0]       wl_c, wh_c, w_range;
  logic [WEIGHT_W-1:0]       held_w;
  logic [GAIN_W-1:0]         gain_sel;
  logic                      upd;

  assign idx    = AW'(axis_r);
  assign held_w = held_r[idx];
  assign et     = {ss_r[VAL_W], ss_r} + {dh_r[VAL_W], dh_r};
  assign eb     = {ss_r[VAL_W], ss_r} + {dl_r[VAL_W], dl_r};
  assign above  = et > (VAL_W+2)'(0);
  assign below  = eb > (VAL_W+2)'(0);
  assign top    = {hi_r[VAL_W-1], hi_r[VAL_W-1], hi_r} - {ss_r[VAL_W], ss_r};
  assign bot    = {lo_r[VAL_W-1], lo_r[VAL_W-1], lo_r} + {ss_r[VAL_W], ss_r};
  assign outside = (dh_r > (VAL_W+1)'(0)) || (dl_r > (VAL_W+1)'(0));

  // Weight ramp: one plus twenty times the signed distance past each edge.
  assign dh_w = {{6{dh_r[VAL_W]}}, dh_r};
  assign dl_w = {{6{dl_r[VAL_W]}}, dl_r};
  assign wl   = (VAL_W+7)'(ONE_Q) + (dh_w <<< 4) + (dh_w <<< 2);
  assign wh   = (VAL_W+7)'(ONE_Q) + (dl_w <<< 4) + (dl_w <<< 2);
  assign wl_c = (wl < (VAL_W+7)'(0)) ? '0 : wl[WEIGHT_W-1:0];
  assign wh_c = (wh < (VAL_W+7)'(0)) ? '0 : wh[WEIGHT_W-1:0];
  assign w_range = outside ? ONE_Q : ((wl_c > wh_c) ? wl_c : wh_c);

  assign gain_sel = (32'(axis_r) < NUM_GAIN) ? gain_r[axis_r] : '0;
  assign upd      = push && !bad_r && en_r && (mode_r == MODE_RANGE);

  always_comb begin
    push_data.err    = '0;
    push_data.gain   = gain_sel;
    push_data.target = want_r;
    push_data.weight = held_w;
    if (bad_r) begin
      push_data.weight = '0;
    end else if (en_r && (mode_r == MODE_PROP)) begin
      push_data.err = {{(ERR_W-VAL_W-1){dw_r[VAL_W]}}, dw_r};
    end else if (en_r && (mode_r == MODE_RANGE)) begin
      push_data.weight = w_range;
      if (above) begin
        push_data.err    = -{et[VAL_W+1], et};
        push_data.target = sat_val(SHIFT_W'(top));
      end else if (below) begin
        push_data.err    = {eb[VAL_W+1], eb};
        push_data.target = sat_val(SHIFT_W'(bot));
      end else begin
        push_data.target = value_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      mode_r <= MODE_PROP;
      for (int i = 0; i < NUM_GAIN; i++) gain_r[i] <= GAIN_RST;
      for (int i = 0; i < AXIS_COUNT; i++) held_r[i] <= ONE_Q;
    end else begin
      if (cfg_en) begin
        if (cfg_index == REG_MODE) begin
          mode_r <= cfg_data[1:0];
        end else if (cfg_index >= REG_GAIN_FIRST && cfg_index <= REG_GAIN_LAST) begin
          gain_r[cfg_index - REG_GAIN_FIRST] <= cfg_data;
        end
      end
      if (a_adv) begin
        a_v_r <= in_ch.valid;
      end
      if (upd) begin
        held_r[idx] <= w_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      axis_r  <= in_ch.axis_index;
      bad_r   <= 32'(in_ch.axis_index) >= AXIS_COUNT;
      en_r    <= in_ch.axis_enabled;
      value_r <= in_ch.measured;
      lo_r    <= in_ch.range_lo;
      hi_r    <= in_ch.range_hi;
      want_r  <= in_ch.desired_in;
      dh_r    <= dh_nxt;
      dl_r    <= dl_nxt;
      dw_r    <= dw_nxt;
      ss_r    <= ss_nxt;
    end
  end

endmodule

FILE: hdl/rdac_queue.sv
// Short first-in first-out queue between the front end and the back end.
// Depends on rdac_pkg for the entry and status types.
module rdac_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rdac_pkg::q_entry_t push_data,
  input  logic               pop,
  output rdac_pkg::q_entry_t head,
  output rdac_pkg::q_stat_t  stat
);
  import rdac_pkg::*;

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head           = mem_r[rd_r];
  assign stat.count     = cnt_r;
  assign stat.not_empty = cnt_r != '0;
  // A full queue still takes a word in the cycle that frees a slot.
  assign stat.space     = (cnt_r != QCNT_W'(QUEUE_DEPTH)) || pop;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= (wr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/rdac_back.sv
// Back end: gain multiply, scaling with saturation and the output register.
// Depends on rdac_pkg and rdac_out_if.
module rdac_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rdac_pkg::q_entry_t head,
  input  rdac_pkg::q_stat_t  q_stat,
  output logic               pop,
  rdac_out_if.source         out_ch
);
  import rdac_pkg::*;

  logic                     m_v_r, o_v_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [VAL_W-1:0]  m_target_r;
  logic [WEIGHT_W-1:0]      m_weight_r;
  logic signed [VAL_W-1:0]  rate_r, target_r;
  logic [WEIGHT_W-1:0]      weight_r;
  logic                     o_adv, m_adv;

  assign o_adv = !o_v_r || out_ch.ready;
  assign m_adv = !m_v_r || o_adv;
  assign pop   = m_adv && q_stat.not_empty;

  assign prod_nxt = $signed({1'b0, head.gain}) * head.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (m_adv) begin
        m_v_r <= q_stat.not_empty;
      end
      if (o_adv) begin
        o_v_r <= m_v_r;
      end
    end
  end

  // The scale by 1/65536 rounds toward minus infinity.
  always_ff @(posedge clk) begin
    if (m_adv) begin
      prod_r     <= prod_nxt;
      m_target_r <= head.target;
      m_weight_r <= head.weight;
    end
    if (o_adv) begin
      rate_r   <= sat_val($signed(prod_r[PROD_W-1:16]));
      target_r <= m_target_r;
      weight_r <= m_weight_r;
    end
  end

  assign out_ch.valid       = o_v_r;
  assign out_ch.rate_out    = rate_r;
  assign out_ch.desired_out = target_r;
  assign out_ch.weight_out  = weight_r;

endmodule

FILE: hdl/range_deadband_axis_controller.sv
// Range deadband axis controller, top level.
// Channels: in_ch carries one axis sample per word (axis number, measured value,
// range bounds, enable flag, desired value); out_ch returns exactly one word per
// sample with the rate command, the target and the axis weight, in sample order.
// Configuration is a plain write port: cfg_en, cfg_index and cfg_data; index 0 is
// the mode, indexes 1 to 6 the gains of axes 0 to 5. Write it only while idle.
// Each word passes the capture register, the queue, the multiply and output registers.
// Throughput is one word per cycle while out_ch.ready stays high; the front end, a
// four-word queue and the two-stage multiply back end each advance on their own.
// Reset sets mode 0, all gains to 1.0 and every held weight to 1.0; no words are
// in flight afterward. When the receiver stalls, the output register holds its
// word, the back end and queue fill, and only then does in_ch.ready drop.
// Depends on rdac_pkg, rdac_in_if, rdac_out_if, rdac_front, rdac_queue, rdac_back.
module range_deadband_axis_controller #(
  parameter int unsigned AXIS_COUNT = rdac_pkg::AXIS_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_en,
  input  logic [rdac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rdac_pkg::CFG_DATA_W-1:0]  cfg_data,
  rdac_in_if.sink                          in_ch,
  rdac_out_if.source                       out_ch
);
  import rdac_pkg::*;

  logic     push, pop;
  q_entry_t push_data, head;
  q_stat_t  q_stat;

  rdac_front #(.AXIS_COUNT(AXIS_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_space   (q_stat.space),
    .push      (push),
    .push_data (push_data)
  );

  rdac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  rdac_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // The queue never holds more words than it has slots.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // The back end only pops a queue that holds a word.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.not_empty)
    else $error("pop from empty queue");

  // A push into a full queue happens only together with a pop.
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (push && q_stat.count == QCNT_W'(QUEUE_DEPTH)) |-> pop)
    else $error("push into full queue");

  // Weights never exceed 1.0.
  a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.weight_out <= ONE_Q))
    else $error("weight above one");

endmodule

FILE: tb/range_deadband_axis_controller_test.sv
// Self-checking testbench of the range deadband axis controller: a directed table, then random
// phases with mode and gain changes, random idling on both channels and long back-pressure.
// Depends on rdac_pkg, rdac_in_if, rdac_out_if and range_deadband_axis_controller.
module range_deadband_axis_controller_test;
  import rdac_pkg::*;

  localparam logic [1:0] MODE_OFF     = 2'd2;
  localparam logic [1:0] MODE_OFF_ALT = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;
  localparam longint WEIGHT_SLOPE    = 20;
  localparam int     SETTLE_CYCLES   = 6;
  localparam int     IDLE_LIMIT      = 2000;
  localparam int     HOLD_OFF_CYCLES = 64;
  localparam int     PHASES          = 10;
  localparam int     PHASE_ITEMS     = 115;
  localparam logic [1:0] PHASE_MODE [PHASES] = '{MODE_RANGE, MODE_PROP, MODE_RANGE, MODE_OFF,
                                                 MODE_RANGE, MODE_OFF_ALT, MODE_RANGE,
                                                 MODE_RANGE, MODE_PROP, MODE_RANGE};

  typedef struct packed {
    logic [AXIS_W-1:0]       axis;
    logic signed [VAL_W-1:0] measured;
    logic signed [VAL_W-1:0] range_lo;
    logic signed [VAL_W-1:0] range_hi;
    logic                    enabled;
    logic signed [VAL_W-1:0] desired;
  } axis_sample_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] rate;
    logic signed [VAL_W-1:0] target;
    logic [WEIGHT_W-1:0]     weight;
  } axis_command_t;

  typedef struct {
    logic [1:0]    mode;
    axis_sample_t  sample;
    bit            known;
    axis_command_t command;
  } vector_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rdac_in_if  in_ch();
  rdac_out_if out_ch();

  range_deadband_axis_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Mirror of the block's configuration and per-axis weights.
  logic [1:0]          mode_copy;
  logic [GAIN_W-1:0]   gain_copy [NUM_GAIN];
  logic [GAIN_W-1:0]   gain_plan [NUM_GAIN];
  logic [WEIGHT_W-1:0] weight_copy [AXIS_COUNT_DEF];

  axis_command_t awaited_commands [$];
  vector_t       vectors [$];
  int            mismatch_count;
  int            in_gap_pct;
  int            out_stall_pct;
  bit            hold_off_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [VAL_W-1:0] clamp32(input longint v);
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    if (v < longint'(VAL_MIN)) return VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] scaled_rate(input logic [GAIN_W-1:0] g,
                                                          input longint err);
    longint product;
    // The arithmetic shift floors the product, as the block does.
    product = longint'({40'd0, g}) * err;
    return clamp32(product >>> 16);
  endfunction

  function automatic axis_command_t axis_command(input axis_sample_t s);
    axis_command_t     c;
    longint            meas;
    longint            lo;
    longint            hi;
    longint            width;
    longint            band;
    longint            top;
    longint            bot;
    longint            wl;
    longint            wh;
    logic [GAIN_W-1:0] g;
    c.rate   = '0;
    c.target = s.desired;
    c.weight = '0;
    if (s.axis >= AXIS_COUNT_DEF) return c;
    g        = gain_copy[s.axis];
    c.weight = weight_copy[s.axis];
    meas     = longint'($signed(s.measured));
    lo       = longint'($signed(s.range_lo));
    hi       = longint'($signed(s.range_hi));
    if (s.enabled && mode_copy == MODE_PROP) begin
      c.rate = scaled_rate(g, longint'($signed(s.desired)) - meas);
    end else if (s.enabled && mode_copy == MODE_RANGE) begin
      width = hi - lo;
      // Narrow and inverted ranges use half the width, floored, as the band.
      band = (width < BAND2_Q) ? (width >>> 1) : longint'(BAND_Q);
      top  = hi - band;
      bot  = lo + band;
      if (meas > top) begin
        c.rate   = scaled_rate(g, top - meas);
        c.target = clamp32(top);
      end else if (meas < bot) begin
        c.rate   = scaled_rate(g, bot - meas);
        c.target = clamp32(bot);
      end else begin
        c.target = s.measured;
      end
      if (meas > hi || meas < lo) begin
        c.weight = ONE_Q;
      end else begin
        wl = longint'(ONE_Q) + WEIGHT_SLOPE * (meas - hi);
        wh = longint'(ONE_Q) + WEIGHT_SLOPE * (lo - meas);
        if (wl < 0) wl = 0;
        if (wh < 0) wh = 0;
        c.weight = (wl > wh) ? wl[WEIGHT_W-1:0] : wh[WEIGHT_W-1:0];
      end
      weight_copy[s.axis] = c.weight;
    end
    return c;
  endfunction

  function automatic void add_vector(input logic [1:0] mode, input int axis, input int meas,
                                     input int lo, input int hi, input bit en, input int des,
                                     input bit known = 1'b0, input int rate = 0,
                                     input int tgt = 0, input int weight = 0);
    vector_t v;
    v.mode    = mode;
    v.sample  = {AXIS_W'(axis), meas, lo, hi, en, des};
    v.known   = known;
    v.command = {rate, tgt, WEIGHT_W'(weight)};
    vectors.insert(vectors.size(), v);
  endfunction

  // Mostly no gap, sometimes a short one and now and then a long one.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return {GAIN_W{1'b1}};
      2:       return GAIN_RST;
      3:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 32'h3FFFF));
    endcase
  endfunction

  // Samples cluster around the range edges, where the band and the weight ramp act.
  function automatic axis_sample_t random_sample();
    axis_sample_t s;
    int           lo;
    int           hi;
    int           meas;
    int           bound;
    s.axis    = ($urandom_range(0, 39) == 0) ? AXIS_W'($urandom_range(6, 7))
                                             : AXIS_W'($urandom_range(0, 5));
    s.enabled = ($urandom_range(0, 9) != 0);
    lo = int'($urandom) >>> $urandom_range(4, 24);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: hi = lo + int'($urandom_range(BAND2_Q, 32'h80000));
      6:                hi = lo + int'($urandom_range(0, BAND2_Q - 1));
      7:                hi = lo - int'($urandom_range(1, 32'h40000));
      8: begin
        lo = $urandom;
        hi = $urandom;
      end
      default: begin
        lo = $urandom_range(0, 1) ? int'(VAL_MIN) : lo;
        hi = VAL_MAX;
      end
    endcase
    bound = $urandom_range(0, 1) ? hi : lo;
    case ($urandom_range(0, 7))
      0, 1:    meas = (hi >= lo) ? lo + int'($urandom_range(0, hi - lo)) : int'($urandom);
      2, 3, 4: meas = bound + int'($urandom_range(0, 4 * BAND_Q)) - 2 * BAND_Q;
      5:       meas = bound + int'($urandom_range(0, 6)) - 3;
      6:       meas = $urandom;
      default: meas = $urandom_range(0, 1) ? int'(VAL_MAX) : int'(VAL_MIN);
    endcase
    s.range_lo = lo;
    s.range_hi = hi;
    s.measured = meas;
    s.desired  = $urandom_range(0, 1) ? int'($urandom)
                                      : meas + int'($urandom_range(0, 32'h40000)) - 32'h20000;
    return s;
  endfunction

  // Waits for every awaited word, then a few cycles more so the pipeline is empty.
  task automatic settle();
    while (awaited_commands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode);
    cfg_en    <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    mode_copy = mode;
    for (int i = 0; i < NUM_GAIN; i++) begin
      cfg_index <= REG_GAIN_FIRST + CFG_IDX_W'(i);
      cfg_data  <= gain_plan[i];
      @(posedge clk);
      gain_copy[i] = gain_plan[i];
    end
    // The spare index must be ignored by the block.
    cfg_index <= REG_UNUSED;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  task automatic offer_sample(input axis_sample_t s, input bit known, input axis_command_t typed);
    int            gap;
    axis_command_t predicted;
    gap = pick_gap(in_gap_pct);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.axis_index   <= s.axis;
    in_ch.measured     <= s.measured;
    in_ch.range_lo     <= s.range_lo;
    in_ch.range_hi     <= s.range_hi;
    in_ch.axis_enabled <= s.enabled;
    in_ch.desired_in   <= s.desired;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = axis_command(s);
    awaited_commands.insert(awaited_commands.size(), known ? typed : predicted);
  endtask

  initial begin : stimulus
    rst_n              <= 1'b0;
    cfg_en             <= 1'b0;
    cfg_index          <= REG_MODE;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.axis_index   <= '0;
    in_ch.measured     <= '0;
    in_ch.range_lo     <= '0;
    in_ch.range_hi     <= '0;
    in_ch.axis_enabled <= 1'b0;
    in_ch.desired_in   <= '0;
    mode_copy = MODE_PROP;
    foreach (gain_copy[a]) begin
      gain_copy[a] = GAIN_RST;
      gain_plan[a] = GAIN_RST;
    end
    foreach (weight_copy[a]) weight_copy[a] = ONE_Q;
    in_gap_pct    = 25;
    out_stall_pct = 25;

    // Proportional mode straight after reset: unit gains and full held weights.
    add_vector(MODE_PROP, 0, 0, 0, 0, 1, 32'sh10000, 1, 32'sh10000, 32'sh10000, ONE_Q);
    add_vector(MODE_PROP, 5, VAL_MAX, 0, 0, 1, VAL_MIN, 1, VAL_MIN, VAL_MIN, ONE_Q);
    add_vector(MODE_PROP, 1, VAL_MIN, 0, 0, 1, VAL_MAX, 1, VAL_MAX, VAL_MAX, ONE_Q);
    add_vector(MODE_PROP, 3, 32'sh18000, 0, 0, 1, 32'sh10000, 1, -32'sh8000, 32'sh10000, ONE_Q);
    add_vector(MODE_PROP, 2, 5, 0, 0, 0, -3, 1, 0, -3, ONE_Q);
    add_vector(MODE_PROP, 6, 0, 0, 0, 1, 32'sh2345, 1, 0, 32'sh2345, 0);
    add_vector(MODE_PROP, 7, VAL_MAX, VAL_MIN, VAL_MAX, 1, VAL_MIN, 1, 0, VAL_MIN, 0);
    // Range controller: dead band center, edges, outside, narrow, empty and inverted ranges.
    add_vector(MODE_RANGE, 0, 0, -32'sh10000, 32'sh10000, 1, 7, 1, 0, 0, 0);
    add_vector(MODE_RANGE, 0, 32'sh10000, -32'sh10000, 32'sh10000, 1, 0);
    add_vector(MODE_RANGE, 1, 32'sh20000, -32'sh10000, 32'sh10000, 1, 0);
    add_vector(MODE_RANGE, 1, -32'sh20000, -32'sh10000, 32'sh10000, 1, 0);
    add_vector(MODE_RANGE, 2, -32'sh10000 + 1000, -32'sh10000, 32'sh10000, 1, 0);
    add_vector(MODE_RANGE, 3, 50, 0, 100, 1, 0);
    add_vector(MODE_RANGE, 3, 80, 0, 100, 1, 0);
    add_vector(MODE_RANGE, 3, 32'sh1234, 32'sh1234, 32'sh1234, 1, 0);
    add_vector(MODE_RANGE, 4, 0, 32'sh10000, -32'sh10000, 1, 0);
    add_vector(MODE_RANGE, 4, VAL_MAX, VAL_MAX, VAL_MIN, 1, 0);
    add_vector(MODE_RANGE, 5, VAL_MAX, VAL_MIN, VAL_MAX, 1, 0);
    add_vector(MODE_RANGE, 5, VAL_MIN, VAL_MIN, VAL_MAX, 1, 0);
    add_vector(MODE_RANGE, 2, 0, -32'sh10000, 32'sh10000, 0, 32'sh777);
    add_vector(MODE_RANGE, 7, 0, 0, 0, 1, 32'sh55, 1, 0, 32'sh55, 0);
    // Held weights must carry over into the other modes.
    add_vector(MODE_PROP, 0, 1, 0, 0, 1, VAL_MAX);
    add_vector(MODE_OFF, 1, 32'sh4000, 0, 0, 1, -32'sh4000);
    add_vector(MODE_OFF_ALT, 4, 32'sh4000, 0, 0, 1, 32'sh99);
    add_vector(MODE_OFF_ALT, 6, 0, 0, 0, 1, -1, 1, 0, -1, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (vectors[k]) begin
      if (vectors[k].mode != mode_copy) begin
        in_ch.valid <= 1'b0;
        settle();
        configure(vectors[k].mode);
      end
      offer_sample(vectors[k].sample, vectors[k].known, vectors[k].command);
    end
    in_ch.valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      foreach (gain_plan[a]) begin
        gain_plan[a] = (p == 1 || p == 7) ? {GAIN_W{1'b1}} : (p == 4) ? '0 : random_gain();
      end
      settle();
      configure(PHASE_MODE[p]);
      in_gap_pct    = $urandom_range(5, 40);
      out_stall_pct = $urandom_range(5, 40);
      if (p == 2) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end
      // The receiver stalls for a long stretch while words keep coming, filling the block.
      if (p == 0 || p == 6) begin
        in_gap_pct   = 0;
        hold_off_req = 1'b1;
      end
      repeat (PHASE_ITEMS) offer_sample(random_sample(), 1'b0, '0);
      in_ch.valid <= 1'b0;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : result_sink
    axis_command_t got;
    axis_command_t want;
    int            stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = {out_ch.rate_out, out_ch.desired_out, out_ch.weight_out};
        if (awaited_commands.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with none awaited: rate %h target %h weight %h",
                   $time, got.rate, got.target, got.weight);
        end else begin
          want = awaited_commands.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: expected rate %h target %h weight %h, got rate %h target %h weight %h",
                     $time, want.rate, want.target, want.weight,
                     got.rate, got.target, got.weight);
          end
        end
      end
      if (hold_off_req) begin
        stall_left   = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else if (stall_left == 0) begin
        stall_left = pick_gap(out_stall_pct);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: range_deadband_axis_controller.f
hdl/rdac_pkg.sv
hdl/rdac_in_if.sv
hdl/rdac_out_if.sv
hdl/rdac_front.sv
hdl/rdac_queue.sv
hdl/rdac_back.sv
hdl/range_deadband_axis_controller.sv
tb/range_deadband_axis_controller_test.sv
